// ===== rtl/core/ows_pkg.sv =====
// Shared types and constants of the 1-Wire ROM search engine.
package ows_pkg;

  localparam int unsigned ROM_W       = 64;  // width of the rom_code result field
  localparam int unsigned LFD_W       = 4;   // last family discrepancy width
  localparam int unsigned FAMILY_END  = 9;   // positions below this lie in the family byte
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam logic [7:0]  CMD_RESET_VAL = 8'hF0;

  typedef enum logic [2:0] {
    OP_FIRST    = 3'd0,
    OP_NEXT     = 3'd1,
    OP_VERIFY   = 3'd2,
    OP_TARGET   = 3'd3,
    OP_SKIP     = 3'd4,
    OP_PRESENCE = 3'd5,
    OP_BITPAIR  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_CMD   = 2'd1,
    ACT_DIR   = 2'd2,
    ACT_DONE  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_BITS     = 2'd2
  } phase_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] family;
    logic       no_device;
    logic       id_bit;
    logic       cmp_bit;
  } item_t;

  typedef struct packed {
    act_e             action;
    logic [7:0]       send_value;
    logic             found;
    logic [ROM_W-1:0] rom_code;
    logic             verified;
    logic             last;
  } res_t;

endpackage

// ===== rtl/core/ows_queue.sv =====
// Small first-in first-out queue of fixed-width entries.
module ows_queue import ows_pkg::*; #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/core/ows_front.sv =====
// Input stage: takes stream transfers, decodes the event code, drops unknown codes.
module ows_front import ows_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [2:0]  s_op_i,
  input  logic [15:0] s_data_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output item_t       item_o
);

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  known;
  op_e   op_dec;

  // Event code decoder
  always_comb begin
    known  = 1'b1;
    op_dec = OP_FIRST;
    unique case (s_op_i)
      OP_FIRST:    op_dec = OP_FIRST;
      OP_NEXT:     op_dec = OP_NEXT;
      OP_VERIFY:   op_dec = OP_VERIFY;
      OP_TARGET:   op_dec = OP_TARGET;
      OP_SKIP:     op_dec = OP_SKIP;
      OP_PRESENCE: op_dec = OP_PRESENCE;
      OP_BITPAIR:  op_dec = OP_BITPAIR;
      default:     known  = 1'b0;
    endcase
  end

  assign s_ready_o    = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (s_ready_o) begin
      // Unknown codes cause nothing: accept and drop them here.
      vld_d            = s_valid_i && known;
      item_d.op        = op_dec;
      item_d.family    = s_data_i[7:0];
      item_d.no_device = s_data_i[8];
      item_d.id_bit    = s_data_i[9];
      item_d.cmp_bit   = s_data_i[10];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ===== rtl/core/ows_back.sv =====
// Search engine: one event per cycle unless stalled; updates state, emits bus actions.
module ows_back import ows_pkg::*; #(
  parameter int unsigned RB = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  item_t      item_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o
);

  localparam int unsigned PW = $clog2(RB + 2);
  localparam int unsigned IW = $clog2(RB);

  logic [RB-1:0]    rom_q, rom_d, bkrom_q, bkrom_d;
  logic [PW-1:0]    ld_q, ld_d, bpos_q, bpos_d, lzp_q, lzp_d, bkld_q, bkld_d;
  logic [LFD_W-1:0] lfd_q, lfd_d, bklfd_q, bklfd_d;
  logic             ldf_q, ldf_d, bkldf_q, bkldf_d;
  logic             ver_q, ver_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       scmd_q;
  logic             pend_vld_q, pend_vld_d;
  res_t             pend_q, pend_d;

  logic exec;
  logic emit0;
  res_t r0, r1;
  logic two;

  assign item_ready_o = res_ready_i && !pend_vld_q;
  assign exec         = item_valid_i && item_ready_o;

  // Next state of the search and the results of the executed event
  always_comb begin
    logic [PW-1:0] pos;
    logic [IW-1:0] sh;
    logic          dir;
    logic          start, fin, fin_ok, ok, vr;

    rom_d   = rom_q;
    ld_d    = ld_q;
    lfd_d   = lfd_q;
    ldf_d   = ldf_q;
    bpos_d  = bpos_q;
    lzp_d   = lzp_q;
    phase_d = phase_q;
    ver_d   = ver_q;
    bkrom_d = bkrom_q;
    bkld_d  = bkld_q;
    bklfd_d = bklfd_q;
    bkldf_d = bkldf_q;
    emit0   = 1'b0;
    two     = 1'b0;
    r0      = '0;
    r1      = '0;
    start   = 1'b0;
    fin     = 1'b0;
    fin_ok  = 1'b0;
    ok      = 1'b0;
    vr      = 1'b0;
    dir     = 1'b0;
    pos     = bpos_q;
    sh      = '0;

    if (exec) begin
      unique case (item_i.op)
        OP_FIRST: begin
          ver_d = 1'b0;
          ld_d  = '0;
          ldf_d = 1'b0;
          lfd_d = '0;
          start = 1'b1;
        end
        OP_NEXT: begin
          ver_d = 1'b0;
          start = 1'b1;
        end
        OP_VERIFY: begin
          bkrom_d = rom_q;
          bkld_d  = ld_q;
          bklfd_d = lfd_q;
          bkldf_d = ldf_q;
          ver_d   = 1'b1;
          ld_d    = PW'(RB);
          ldf_d   = 1'b0;
          start   = 1'b1;
        end
        OP_TARGET: begin
          phase_d = PH_IDLE;
          ver_d   = 1'b0;
          rom_d   = RB'(item_i.family);
          ld_d    = PW'(RB);
          lfd_d   = '0;
          ldf_d   = 1'b0;
        end
        OP_SKIP: begin
          phase_d = PH_IDLE;
          ver_d   = 1'b0;
          ld_d    = PW'(lfd_q);
          lfd_d   = '0;
          if (lfd_q == '0) begin
            ldf_d = 1'b1;
          end
        end
        OP_PRESENCE: begin
          if (phase_q == PH_PRESENCE) begin
            if (item_i.no_device) begin
              fin = 1'b1;
            end else begin
              phase_d       = PH_BITS;
              bpos_d        = PW'(1);
              lzp_d         = '0;
              emit0         = 1'b1;
              r0.action     = ACT_CMD;
              r0.send_value = scmd_q;
              r0.rom_code   = ROM_W'(rom_d);
              r0.last       = 1'b1;
            end
          end
        end
        OP_BITPAIR: begin
          if (phase_q == PH_BITS) begin
            if (bpos_q < PW'(1) || bpos_q > PW'(RB)) begin
              pos = PW'(1);
            end
            if (item_i.id_bit && item_i.cmp_bit) begin
              fin = 1'b1;
            end else begin
              sh = IW'(pos - PW'(1));
              if (item_i.id_bit != item_i.cmp_bit) begin
                dir = item_i.id_bit;
              end else begin
                if (pos < ld_q) begin
                  dir = rom_q[sh];
                end else begin
                  dir = (pos == ld_q);
                end
                if (!dir) begin
                  lzp_d = pos;
                  if (pos < PW'(FAMILY_END)) begin
                    lfd_d = LFD_W'(pos);
                  end
                end
              end
              rom_d[sh]     = dir;
              bpos_d        = pos + PW'(1);
              emit0         = 1'b1;
              r0.action     = ACT_DIR;
              r0.send_value = 8'(dir);
              r0.rom_code   = ROM_W'(rom_d);
              r0.last       = !(pos >= PW'(RB));
              if (pos >= PW'(RB)) begin
                ld_d = lzp_d;
                if (lzp_d == '0) begin
                  ldf_d = 1'b1;
                end
                fin    = 1'b1;
                fin_ok = 1'b1;
                two    = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (start) begin
      bpos_d = PW'(1);
      lzp_d  = '0;
      if (ldf_d) begin
        fin = 1'b1;
      end else begin
        phase_d     = PH_PRESENCE;
        emit0       = 1'b1;
        r0.action   = ACT_RESET;
        r0.rom_code = ROM_W'(rom_d);
        r0.last     = 1'b1;
      end
    end

    if (fin) begin
      ok = fin_ok && (rom_d[7:0] != 8'd0);
      if (!ok) begin
        ld_d  = '0;
        ldf_d = 1'b0;
        lfd_d = '0;
      end
      if (ver_d) begin
        vr    = ok && (rom_d == bkrom_d);
        rom_d = bkrom_d;
        ld_d  = bkld_d;
        lfd_d = bklfd_d;
        ldf_d = bkldf_d;
        ver_d = 1'b0;
      end
      phase_d = PH_IDLE;
      if (two) begin
        r1.action   = ACT_DONE;
        r1.found    = ok;
        r1.rom_code = ROM_W'(rom_d);
        r1.verified = vr;
        r1.last     = 1'b1;
      end else begin
        emit0       = 1'b1;
        r0.action   = ACT_DONE;
        r0.found    = ok;
        r0.rom_code = ROM_W'(rom_d);
        r0.verified = vr;
        r0.last     = 1'b1;
      end
    end
  end

  // Result hand-off: a held second result goes out before the next event runs
  always_comb begin
    pend_d = pend_q;
    if (pend_vld_q) begin
      res_valid_o = 1'b1;
      res_o       = pend_q;
      pend_vld_d  = !res_ready_i;
    end else begin
      res_valid_o = emit0;
      res_o       = r0;
      pend_vld_d  = two;
      if (two) begin
        pend_d = r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q      <= '0;
      ld_q       <= '0;
      lfd_q      <= '0;
      ldf_q      <= 1'b0;
      bpos_q     <= PW'(1);
      lzp_q      <= '0;
      phase_q    <= PH_IDLE;
      ver_q      <= 1'b0;
      scmd_q     <= CMD_RESET_VAL;
      pend_vld_q <= 1'b0;
    end else begin
      rom_q      <= rom_d;
      ld_q       <= ld_d;
      lfd_q      <= lfd_d;
      ldf_q      <= ldf_d;
      bpos_q     <= bpos_d;
      lzp_q      <= lzp_d;
      phase_q    <= phase_d;
      ver_q      <= ver_d;
      pend_vld_q <= pend_vld_d;
      if (cfg_valid_i) begin
        scmd_q <= cfg_data_i;
      end
    end
  end

  // Backup and held result carry no reset
  always_ff @(posedge clk_i) begin
    bkrom_q <= bkrom_d;
    bkld_q  <= bkld_d;
    bklfd_q <= bklfd_d;
    bkldf_q <= bkldf_d;
    pend_q  <= pend_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (pend_q.action == ACT_DONE) && pend_q.last)
    else $error("held result is not a final done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BITS) |-> (bpos_q >= PW'(1)) && (bpos_q <= PW'(RB)))
    else $error("bit position out of range during bit phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ver_q |-> (phase_q != PH_IDLE))
    else $error("verify pending while no search runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && two) |=> pend_vld_q && !item_ready_o)
    else $error("second result not held");

endmodule

// ===== rtl/core/onewire_rom_search_engine_top.sv =====
// Path: input register, item queue, engine logic, result queue, then the master side.
// Throughput: one event per cycle unless the result side stalls or a second result is held.
// The engine loop (state update and result selection) is combinational logic.
// Reset: search state cleared, bit position one, search command 0xF0, queues empty.
// The verify backup holds no reset value; no clearing pass is run.
module onewire_rom_search_engine_top import ows_pkg::*; #(
  parameter int unsigned ROM_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [7:0]             cfg_data_i,     // search_command
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // family_code, no_device, id_bit, cmp_bit
  input  logic [2:0]             s_axis_tuser,   // op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // send_value, found, rom_code, verified
  output logic [1:0]             m_axis_tuser,   // action
  output logic                   m_axis_tlast
);

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(res_t);

  logic  fr_valid, fr_ready;
  item_t fr_item;
  logic  iq_valid, iq_ready;
  item_t iq_item;
  logic  rs_valid, rs_ready;
  res_t  rs_res;
  res_t  out_res;

  assign cfg_ready_o = 1'b1;

  ows_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_op_i       (s_axis_tuser),
    .s_data_i     (s_axis_tdata),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  ows_queue #(.DW(ITEM_W), .DEPTH(2)) u_item_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_item),
    .pop_valid_o  (iq_valid),
    .pop_ready_i  (iq_ready),
    .pop_data_o   (iq_item)
  );

  ows_back #(.RB(ROM_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (iq_valid),
    .item_ready_o (iq_ready),
    .item_i       (iq_item),
    .res_valid_o  (rs_valid),
    .res_ready_i  (rs_ready),
    .res_o        (rs_res)
  );

  ows_queue #(.DW(RES_W), .DEPTH(2)) u_res_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (rs_valid),
    .push_ready_o (rs_ready),
    .push_data_i  (rs_res),
    .pop_valid_o  (m_axis_tvalid),
    .pop_ready_i  (m_axis_tready),
    .pop_data_o   (out_res)
  );

  assign m_axis_tuser = out_res.action;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tdata = {6'd0, out_res.verified, out_res.rom_code, out_res.found,
                         out_res.send_value};

endmodule

// ===== dv/onewire_rom_search_engine_top_tb.sv =====
// Self-checking testbench for the 1-Wire ROM search engine top level.
`timescale 1ns / 1ps

module onewire_rom_search_engine_top_tb;
  import ows_pkg::*;

  localparam int ROM_LEN    = ROM_W;
  localparam int LONG_HOLD  = 400;
  localparam int STALL_MAX  = 3000;
  localparam int SETTLE_CYC = 6;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [7:0]             cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // family_code, no_device, id_bit, cmp_bit
  logic [2:0]             s_axis_tuser  = '0;   // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // send_value, found, rom_code, verified
  logic [1:0]             m_axis_tuser;         // action
  logic                   m_axis_tlast;

  onewire_rom_search_engine_top #(.ROM_BITS(ROM_LEN)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Event stream and expected bus actions
  item_t event_q[$];
  res_t  action_q[$];

  // Shadow search state
  logic [7:0]         search_cmd;
  logic [ROM_LEN-1:0] rom_reg;
  logic [6:0]         last_disc;
  logic [3:0]         last_fam_disc;
  logic               last_dev;
  logic [6:0]         bit_pos;
  logic [6:0]         zero_pos;
  phase_e             srch_phase;
  logic               verifying;
  logic [ROM_LEN-1:0] saved_rom;
  logic [11:0]        saved_disc;

  int mismatches   = 0;
  int events_acc   = 0;
  int results_seen = 0;
  int found_cnt    = 0;
  int verified_cnt = 0;
  int cfg_writes   = 0;
  int gen_count    = 0;
  int stall_cycles = 0;

  logic               src_idle_en = 1'b1;
  logic               snk_idle_en = 1'b1;
  int                 long_hold_req = 0;
  logic [ROM_LEN-1:0] clean_rom = '0;
  logic               have_clean = 1'b0;

  task push_result(input act_e a, input logic [7:0] v, input logic f, input logic ver,
                   input logic l);
    res_t r;
    r.action     = a;
    r.send_value = v;
    r.found      = f;
    r.rom_code   = rom_reg;
    r.verified   = ver;
    r.last       = l;
    action_q.push_back(r);
  endtask

  task clear_search();
    last_disc     = '0;
    last_dev      = 1'b0;
    last_fam_disc = '0;
  endtask

  // End the search; a verify restores the saved state after the compare
  task close_search(input logic ok);
    logic ver;
    logic okf;
    ver = 1'b0;
    okf = ok;
    if (!okf || rom_reg[7:0] == 8'd0) begin
      clear_search();
      okf = 1'b0;
    end
    if (verifying) begin
      ver           = okf && (rom_reg == saved_rom);
      rom_reg       = saved_rom;
      last_disc     = saved_disc[6:0];
      last_fam_disc = saved_disc[10:7];
      last_dev      = saved_disc[11];
      verifying     = 1'b0;
    end
    srch_phase = PH_IDLE;
    push_result(ACT_DONE, 8'd0, okf, ver, 1'b1);
  endtask

  task open_search();
    bit_pos  = 7'd1;
    zero_pos = 7'd0;
    if (last_dev) begin
      close_search(1'b0);
    end else begin
      srch_phase = PH_PRESENCE;
      push_result(ACT_RESET, 8'd0, 1'b0, 1'b0, 1'b1);
    end
  endtask

  task predict_actions(input item_t ev);
    logic [6:0] p;
    logic       dir;
    case (ev.op)
      OP_FIRST: begin
        verifying = 1'b0;
        clear_search();
        open_search();
      end
      OP_NEXT: begin
        verifying = 1'b0;
        open_search();
      end
      OP_VERIFY: begin
        saved_rom  = rom_reg;
        saved_disc = {last_dev, last_fam_disc, last_disc};
        verifying  = 1'b1;
        last_disc  = 7'(ROM_LEN);
        last_dev   = 1'b0;
        open_search();
      end
      OP_TARGET: begin
        srch_phase    = PH_IDLE;
        verifying     = 1'b0;
        rom_reg       = {{(ROM_LEN-8){1'b0}}, ev.family};
        last_disc     = 7'(ROM_LEN);
        last_fam_disc = '0;
        last_dev      = 1'b0;
      end
      OP_SKIP: begin
        srch_phase    = PH_IDLE;
        verifying     = 1'b0;
        last_disc     = {3'd0, last_fam_disc};
        last_fam_disc = '0;
        if (last_disc == 7'd0) last_dev = 1'b1;
      end
      OP_PRESENCE: begin
        if (srch_phase == PH_PRESENCE) begin
          if (ev.no_device) begin
            close_search(1'b0);
          end else begin
            srch_phase = PH_BITS;
            bit_pos    = 7'd1;
            zero_pos   = 7'd0;
            push_result(ACT_CMD, search_cmd, 1'b0, 1'b0, 1'b1);
          end
        end
      end
      OP_BITPAIR: begin
        if (srch_phase == PH_BITS) begin
          p = bit_pos;
          if (p < 7'd1 || p > 7'(ROM_LEN)) p = 7'd1;
          if (ev.id_bit && ev.cmp_bit) begin
            close_search(1'b0);
          end else begin
            if (ev.id_bit != ev.cmp_bit) begin
              dir = ev.id_bit;
            end else begin
              // discrepancy: repeat the old path below the last one, take 1 at it
              if (p < last_disc) dir = rom_reg[p-1];
              else dir = (p == last_disc);
              if (!dir) begin
                zero_pos = p;
                if (p < FAMILY_END) last_fam_disc = p[3:0];
              end
            end
            rom_reg[p-1] = dir;
            bit_pos      = p + 7'd1;
            if (p >= 7'(ROM_LEN)) begin
              push_result(ACT_DIR, {7'd0, dir}, 1'b0, 1'b0, 1'b0);
              last_disc = zero_pos;
              if (last_disc == 7'd0) last_dev = 1'b1;
              close_search(1'b1);
            end else begin
              push_result(ACT_DIR, {7'd0, dir}, 1'b0, 1'b0, 1'b1);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Source side: offer the head of the event queue, idle in bursts
  always @(posedge clk_i or negedge rst_ni) begin : src_drv
    int src_gap;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_actions(event_q[0]);
        void'(event_q.pop_front());
        events_acc++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered transfer
      end else if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (event_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (src_idle_en && $urandom_range(0, 15) == 0) begin
        src_gap = $urandom_range(1, 15) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= event_q[0].op;
        s_axis_tdata  <= {5'd0, event_q[0].cmp_bit, event_q[0].id_bit,
                          event_q[0].no_device, event_q[0].family};
      end
    end
  end

  // Sink side: random ready bursts, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : snk_drv
    int snk_gap;
    int hold_seen;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap   = 0;
      hold_seen = 0;
    end else if (hold_seen != long_hold_req) begin
      hold_seen = long_hold_req;
      snk_gap   = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 11) == 0) begin
      snk_gap = $urandom_range(1, 15) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin : result_mon
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action     = act_e'(m_axis_tuser);
      got.send_value = m_axis_tdata[7:0];
      got.found      = m_axis_tdata[8];
      got.rom_code   = m_axis_tdata[9 +: ROM_LEN];
      got.verified   = m_axis_tdata[9 + ROM_LEN];
      got.last       = m_axis_tlast;
      results_seen++;
      if (action_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result action=%0d value=%02h rom=%016h",
                   got.action, got.send_value, got.rom_code);
      end else begin
        want = action_q.pop_front();
        if (got.action !== want.action || got.send_value !== want.send_value ||
            got.found !== want.found || got.rom_code !== want.rom_code ||
            got.verified !== want.verified || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: exp act=%0d val=%02h fnd=%b rom=%016h ver=%b last=%b",
                     want.action, want.send_value, want.found, want.rom_code,
                     want.verified, want.last);
            $display("       got act=%0d val=%02h fnd=%b rom=%016h ver=%b last=%b",
                     got.action, got.send_value, got.found, got.rom_code,
                     got.verified, got.last);
          end
        end
        if (want.action == ACT_DONE && want.found) found_cnt++;
        if (want.verified) verified_cnt++;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("timeout after %0d cycles without a transfer", stall_cycles);
        $display("onewire_rom_search_engine_top regression: fail");
        $finish;
      end
    end
  end

  task add_event(input logic [2:0] o, input logic [7:0] f, input logic nd,
                 input logic idb, input logic cmb);
    item_t ev;
    ev.op        = op_e'(o);
    ev.family    = f;
    ev.no_device = nd;
    ev.id_bit    = idb;
    ev.cmp_bit   = cmb;
    event_q.push_back(ev);
    gen_count++;
  endtask

  task add_noise();
    add_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // One search sequence: start, presence, bit pairs; some are cut short
  task gen_search();
    int                 kind;
    int                 r;
    int                 stop_at;
    int                 i;
    logic               nd;
    logic               clean;
    logic               idb;
    logic [ROM_LEN-1:0] bits;
    logic [2:0]         o;
    kind  = $urandom_range(0, 9);
    clean = (kind <= 3);
    bits  = {$urandom, $urandom};
    if (kind == 0) bits[7:0] = 8'd0;
    if (kind == 3 && have_clean) begin
      bits = clean_rom;
      o    = OP_VERIFY;
    end else begin
      r = $urandom_range(0, 9);
      o = (r < 5) ? OP_NEXT : (r < 8) ? OP_FIRST : OP_VERIFY;
    end
    add_event(o, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    nd = ($urandom_range(0, 11) == 0);
    add_event(OP_PRESENCE, 8'($urandom), nd, 1'($urandom), 1'($urandom));
    stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ROM_LEN - 1) : ROM_LEN;
    for (i = 0; i < stop_at; i++) begin
      if (clean) begin
        add_event(OP_BITPAIR, 8'($urandom), 1'($urandom), bits[i], ~bits[i]);
      end else begin
        r   = $urandom_range(0, 99);
        idb = 1'($urandom);
        if (r < 2) begin
          add_event(OP_BITPAIR, 8'($urandom), 1'($urandom), 1'b1, 1'b1);
          break;
        end else if (r < 30) begin
          add_event(OP_BITPAIR, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
        end else begin
          add_event(OP_BITPAIR, 8'($urandom), 1'($urandom), idb, ~idb);
        end
      end
    end
    // cut the search short with a new start or a setup
    if (stop_at < ROM_LEN)
      add_event(3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom));
    else if (clean && !nd && bits[7:0] != 8'd0) begin
      clean_rom  = bits;
      have_clean = 1'b1;
    end
  endtask

  task fill_random(input int n);
    int r;
    int k;
    gen_count = 0;
    while (gen_count < n) begin
      r = $urandom_range(0, 9);
      if (r < 7) gen_search();
      else for (k = 0; k < $urandom_range(1, 4); k++) add_noise();
    end
  endtask

  task write_search_cmd(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    search_cmd = v;
    cfg_writes++;
  endtask

  // Wait until every event is in and every result is out, then let the pipe drain
  task settle();
    while (event_q.size() != 0 || action_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  initial begin
    search_cmd    = CMD_RESET_VAL;
    rom_reg       = '0;
    clear_search();
    bit_pos       = 7'd1;
    zero_pos      = 7'd0;
    srch_phase    = PH_IDLE;
    verifying     = 1'b0;
    saved_rom     = '0;
    saved_disc    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: setups, out-of-phase events, aborts and restarts
    write_search_cmd(8'h00);
    add_event(OP_TARGET,   8'hFF, 1'b0, 1'b0, 1'b0);
    add_event(OP_SKIP,     8'h00, 1'b1, 1'b1, 1'b1);   // no family discrepancy: last device
    add_event(OP_NEXT,     8'h00, 1'b0, 1'b0, 1'b0);   // done at once, no bus reset
    add_event(OP_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0);   // out of phase
    add_event(OP_BITPAIR,  8'h00, 1'b0, 1'b1, 1'b0);   // out of phase
    add_event(3'd7,        8'hFF, 1'b1, 1'b1, 1'b1);   // unused op
    add_event(OP_FIRST,    8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_PRESENCE, 8'hFF, 1'b1, 1'b0, 1'b0);   // no device answered
    add_event(OP_VERIFY,   8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_BITPAIR,  8'h00, 1'b0, 1'b1, 1'b0);
    add_event(OP_BITPAIR,  8'h00, 1'b0, 1'b0, 1'b1);
    add_event(OP_BITPAIR,  8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_BITPAIR,  8'h00, 1'b0, 1'b1, 1'b1);   // both ones: abort, verify restores
    add_event(OP_FIRST,    8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_BITPAIR,  8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_TARGET,   8'h00, 1'b0, 1'b0, 1'b0);   // setup drops the search
    add_event(OP_BITPAIR,  8'h00, 1'b0, 1'b0, 1'b1);
    add_event(OP_NEXT,     8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0);
    add_event(OP_VERIFY,   8'h00, 1'b0, 1'b0, 1'b0);   // start while searching
    add_event(OP_SKIP,     8'h00, 1'b0, 1'b0, 1'b0);   // setup drops the verify
    add_event(OP_FIRST,    8'h00, 1'b0, 1'b0, 1'b0);
    settle();

    write_search_cmd(8'hFF);
    fill_random(400);
    settle();

    // Back-pressure: sink stalls while the source streams without gaps
    write_search_cmd(8'hEC);
    src_idle_en = 1'b0;
    long_hold_req++;
    fill_random(300);
    settle();

    write_search_cmd(8'($urandom_range(1, 254)));
    snk_idle_en = 1'b0;
    fill_random(300);
    settle();

    if (action_q.size() != 0) mismatches++;
    $display("covered %0d events and %0d results under %0d command settings",
             events_acc, results_seen, cfg_writes);
    $display("searches with a device found: %0d, verifies confirmed: %0d, mismatches: %0d",
             found_cnt, verified_cnt, mismatches);
    if (mismatches == 0) begin
      $display("onewire_rom_search_engine_top regression: pass");
    end else begin
      $display("onewire_rom_search_engine_top regression: fail");
    end
    $finish;
  end

endmodule
